>>> sv/wcbf_pkg.sv
// ----------------------------------------------------------------------------
// wcbf_pkg
// types and fixed constants shared by the cluster/block framer modules
// ----------------------------------------------------------------------------
package wcbf_pkg;

    // result kinds
    localparam logic [1:0] KIND_BYTE   = 2'd0;
    localparam logic [1:0] KIND_PATCH  = 2'd1;
    localparam logic [1:0] KIND_REJECT = 2'd2;

    // configuration register indexes
    localparam int unsigned    CFG_IDX_BITS      = 2;
    localparam logic [1:0]     CFG_FIRST_CLUSTER = 2'd0;
    localparam logic [1:0]     CFG_SEGMENT_DATA  = 2'd1;
    localparam logic [47:0]    SEG_OFFSET_RESET  = 48'd8;

    // ns to ms conversion: quotient of a 63-bit value by 1e6 fits 44 bits
    localparam int unsigned    TS_BITS       = 63;
    localparam int unsigned    MS_BITS       = 44;
    localparam int unsigned    REM_BITS      = 20;
    localparam logic [20:0]    NS_PER_MS     = 21'd1000000;
    localparam int unsigned    DIV_STEP_BITS = 4;
    localparam int unsigned    DIV_CYCLES    = MS_BITS / DIV_STEP_BITS;
    localparam int unsigned    DIV_CNT_BITS  = $clog2(DIV_CYCLES);

    // matroska element bytes
    localparam logic [31:0]    CLUSTER_ID     = 32'h1F43B675;
    localparam logic [7:0]     UNKNOWN_LEAD   = 8'h01;
    localparam logic [7:0]     UNKNOWN_FILL   = 8'hFF;
    localparam logic [7:0]     TIMECODE_ID    = 8'hE7;
    localparam logic [7:0]     SIMPLEBLOCK_ID = 8'hA3;
    localparam logic [7:0]     TRACK_BYTE     = 8'h81;
    localparam logic [7:0]     VINT_LEN1      = 8'h80;
    localparam logic [7:0]     KEY_FLAG       = 8'h80;
    localparam logic [44:0]    MAX_CLUSTER_MS = 45'd5000;

    typedef struct packed {
        logic        command;
        logic [62:0] timestamp_ns;
        logic        keyframe;
        logic [31:0] payload_length;
    } t_wcbf_in;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  byte_value;
        logic [47:0] patch_offset;
        logic [55:0] patch_length;
        logic        last;
    } t_wcbf_out;

    // descriptor after timestamp conversion
    typedef struct packed {
        logic                command;
        logic [MS_BITS-1:0]  ms;
        logic                keyframe;
        logic [31:0]         payload_length;
    } t_wcbf_item;

    typedef struct packed {
        logic                    we;
        logic [CFG_IDX_BITS-1:0] index;
        logic [47:0]             data;
    } t_wcbf_cfg;

endpackage

>>> sv/wcbf_front.sv
// ----------------------------------------------------------------------------
// wcbf_front
// accepts descriptors and converts the timestamp to milliseconds
// ----------------------------------------------------------------------------
module wcbf_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  wcbf_pkg::t_wcbf_in   i_in_data,
    input  logic                 i_q_full,
    output logic                 o_q_push,
    output wcbf_pkg::t_wcbf_item o_q_item
);
    import wcbf_pkg::*;

    logic                    r_busy;
    logic                    r_done;
    logic [DIV_CNT_BITS-1:0] r_step;
    logic [REM_BITS-1:0]     r_rem;
    logic [MS_BITS-1:0]      r_qd;
    logic                    r_cmd;
    logic                    r_key;
    logic [31:0]             r_plen;
    logic [REM_BITS-1:0]     n_rem;
    logic [MS_BITS-1:0]      n_qd;
    logic                    w_accept;

    assign o_in_stall = r_busy | (r_done & i_q_full);
    assign w_accept   = i_in_valid & ~o_in_stall;
    assign o_q_push   = r_done & ~i_q_full;

    assign o_q_item.command        = r_cmd;
    assign o_q_item.ms             = r_qd;
    assign o_q_item.keyframe       = r_key;
    assign o_q_item.payload_length = r_plen;

    // restoring division, a few quotient bits per cycle
    always_comb begin
        logic [REM_BITS:0]  t;
        logic [REM_BITS-1:0] rem;
        logic [MS_BITS-1:0]  qd;
        rem = r_rem;
        qd  = r_qd;
        for (int k = 0; k < DIV_STEP_BITS; k++) begin
            t  = {rem, qd[MS_BITS-1]};
            qd = {qd[MS_BITS-2:0], 1'b0};
            if (t >= NS_PER_MS) begin
                t     = t - NS_PER_MS;
                qd[0] = 1'b1;
            end
            rem = t[REM_BITS-1:0];
        end
        n_rem = rem;
        n_qd  = qd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            if (o_q_push) begin
                r_done <= 1'b0;
            end
            if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == DIV_CNT_BITS'(DIV_CYCLES - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end else if (w_accept) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_rem <= n_rem;
            r_qd  <= n_qd;
        end else if (w_accept) begin
            r_rem  <= REM_BITS'(i_in_data.timestamp_ns[TS_BITS-1:MS_BITS]);
            r_qd   <= i_in_data.timestamp_ns[MS_BITS-1:0];
            r_cmd  <= i_in_data.command;
            r_key  <= i_in_data.keyframe;
            r_plen <= i_in_data.payload_length;
        end
    end

endmodule

>>> sv/wcbf_queue.sv
// ----------------------------------------------------------------------------
// wcbf_queue
// two-entry descriptor queue between front and back
// ----------------------------------------------------------------------------
module wcbf_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  wcbf_pkg::t_wcbf_item i_item,
    output logic                 o_full,
    output logic                 o_valid,
    input  logic                 i_pop,
    output wcbf_pkg::t_wcbf_item o_item
);
    import wcbf_pkg::*;

    t_wcbf_item r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_full  = r_cnt[1];
    assign o_valid = r_cnt != 2'd0;
    assign o_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

endmodule

>>> sv/wcbf_back.sv
// ----------------------------------------------------------------------------
// wcbf_back
// cluster state, byte sequencer and result register
// ----------------------------------------------------------------------------
module wcbf_back #(
    parameter int OFFSET_BITS       = 48,
    parameter int FRAME_LENGTH_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  wcbf_pkg::t_wcbf_cfg  i_cfg,
    input  logic                 i_q_valid,
    input  wcbf_pkg::t_wcbf_item i_q_item,
    output logic                 o_q_pop,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output wcbf_pkg::t_wcbf_out  o_out_data
);
    import wcbf_pkg::*;

    localparam int OB = OFFSET_BITS;
    localparam int PW = (FRAME_LENGTH_BITS < 32) ? FRAME_LENGTH_BITS : 32;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_REJECT = 3'd1;
    localparam logic [2:0] ST_CPATCH = 3'd2;
    localparam logic [2:0] ST_SPATCH = 3'd3;
    localparam logic [2:0] ST_CLHDR  = 3'd4;
    localparam logic [2:0] ST_BLOCK  = 3'd5;

    // stream state
    logic               r_cl_open;
    logic [OB-1:0]      r_cl_field_off;
    logic [MS_BITS-1:0] r_cl_start_ms;
    logic [OB-1:0]      r_out_off;
    logic               r_closed;
    logic [47:0]        r_seg_off;

    // current item
    logic               r_fin;
    logic               r_key;
    logic [MS_BITS-1:0] r_ms;
    logic [PW-1:0]      r_plen;
    logic [15:0]        r_rel;
    logic [2:0]         r_n;
    logic [3:0]         r_szk;
    logic [63:0]        r_szval;

    logic [2:0]         r_state;
    logic [2:0]         n_state;
    logic [4:0]         r_cnt;
    logic [4:0]         n_cnt;

    logic               r_out_valid;
    t_wcbf_out          r_out;

    logic               w_adv;
    logic               w_emit;
    t_wcbf_out          w_res;
    logic [OB-1:0]      w_seg;
    logic [MS_BITS:0]   w_diff;
    logic               w_late;
    logic               w_new;
    logic [PW-1:0]      w_plen;
    logic [63:0]        w_s;
    logic [3:0]         w_szk;
    logic [63:0]        w_szval;
    logic [2:0]         w_n;
    logic [4:0]         w_hdr_last;
    logic [4:0]         w_blk_last;
    logic [2:0]         w_ms_bi;
    logic [2:0]         w_sz_bi;
    logic [1:0]         w_id_bi;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign w_adv   = ~r_out_valid | ~i_out_stall;
    assign w_emit  = w_adv & (r_state != ST_IDLE);
    assign o_q_pop = (r_state == ST_IDLE) & i_q_valid;
    assign w_seg   = OB'(r_seg_off);

    // dispatch decisions
    assign w_diff = {1'b0, i_q_item.ms} - {1'b0, r_cl_start_ms};
    assign w_late = ~w_diff[MS_BITS] & (w_diff > MAX_CLUSTER_MS);
    assign w_new  = ~r_cl_open | i_q_item.keyframe | w_late;
    assign w_plen = PW'(i_q_item.payload_length);
    assign w_s    = 64'(w_plen) + 64'd4;

    always_comb begin
        if (i_q_item.ms[43:40] != '0) begin
            w_n = 3'd6;
        end else if (i_q_item.ms[39:32] != '0) begin
            w_n = 3'd5;
        end else if (i_q_item.ms[31:24] != '0) begin
            w_n = 3'd4;
        end else if (i_q_item.ms[23:16] != '0) begin
            w_n = 3'd3;
        end else if (i_q_item.ms[15:8] != '0) begin
            w_n = 3'd2;
        end else begin
            w_n = 3'd1;
        end
    end

    // ebml size with its length marker, all-ones codes avoided
    always_comb begin
        if (w_s < 64'h7F) begin
            w_szk   = 4'd1;
            w_szval = w_s | 64'h80;
        end else if (w_s < 64'h3FFF) begin
            w_szk   = 4'd2;
            w_szval = w_s | 64'h4000;
        end else if (w_s < 64'h1F_FFFF) begin
            w_szk   = 4'd3;
            w_szval = w_s | 64'h20_0000;
        end else if (w_s < 64'h0FFF_FFFF) begin
            w_szk   = 4'd4;
            w_szval = w_s | 64'h1000_0000;
        end else begin
            w_szk   = 4'd8;
            w_szval = w_s | 64'h0100_0000_0000_0000;
        end
    end

    // byte positions
    assign w_hdr_last = 5'd13 + 5'(r_n);
    assign w_blk_last = 5'(r_szk) + 5'd4;
    assign w_ms_bi    = 3'(w_hdr_last - r_cnt);
    assign w_sz_bi    = 3'(5'(r_szk) - r_cnt);
    assign w_id_bi    = 2'd3 - r_cnt[1:0];

    always_comb begin
        logic [OB-1:0] len;
        w_res      = '0;
        w_res.kind = KIND_BYTE;
        len        = '0;
        case (r_state)
            ST_REJECT: begin
                w_res.kind = KIND_REJECT;
                w_res.last = 1'b1;
            end
            ST_CPATCH: begin
                len                = r_out_off - (r_cl_field_off + OB'(8));
                w_res.kind         = KIND_PATCH;
                w_res.patch_offset = 48'(r_cl_field_off);
                w_res.patch_length = 56'(len);
            end
            ST_SPATCH: begin
                len                = r_out_off - w_seg;
                w_res.kind         = KIND_PATCH;
                w_res.patch_offset = 48'(w_seg - OB'(8));
                w_res.patch_length = 56'(len);
                w_res.last         = 1'b1;
            end
            ST_CLHDR: begin
                if (r_cnt < 5'd4) begin
                    w_res.byte_value = 8'(CLUSTER_ID >> {w_id_bi, 3'b000});
                end else if (r_cnt == 5'd4) begin
                    w_res.byte_value = UNKNOWN_LEAD;
                end else if (r_cnt < 5'd12) begin
                    w_res.byte_value = UNKNOWN_FILL;
                end else if (r_cnt == 5'd12) begin
                    w_res.byte_value = TIMECODE_ID;
                end else if (r_cnt == 5'd13) begin
                    w_res.byte_value = VINT_LEN1 | 8'(r_n);
                end else begin
                    w_res.byte_value = 8'(r_ms >> {w_ms_bi, 3'b000});
                end
            end
            ST_BLOCK: begin
                if (r_cnt == 5'd0) begin
                    w_res.byte_value = SIMPLEBLOCK_ID;
                end else if (r_cnt <= 5'(r_szk)) begin
                    w_res.byte_value = 8'(r_szval >> {w_sz_bi, 3'b000});
                end else if (r_cnt == 5'(r_szk) + 5'd1) begin
                    w_res.byte_value = TRACK_BYTE;
                end else if (r_cnt == 5'(r_szk) + 5'd2) begin
                    w_res.byte_value = r_rel[15:8];
                end else if (r_cnt == 5'(r_szk) + 5'd3) begin
                    w_res.byte_value = r_rel[7:0];
                end else begin
                    w_res.byte_value = r_key ? KEY_FLAG : 8'h00;
                    w_res.last       = 1'b1;
                end
            end
            default: begin
                w_res = '0;
            end
        endcase
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    n_cnt = 5'd0;
                    if (r_closed) begin
                        n_state = ST_REJECT;
                    end else if (i_q_item.command) begin
                        n_state = r_cl_open ? ST_CPATCH : ST_SPATCH;
                    end else if (w_new) begin
                        n_state = r_cl_open ? ST_CPATCH : ST_CLHDR;
                    end else begin
                        n_state = ST_BLOCK;
                    end
                end
            end
            ST_REJECT, ST_SPATCH: begin
                if (w_adv) begin
                    n_state = ST_IDLE;
                end
            end
            ST_CPATCH: begin
                if (w_adv) begin
                    n_state = r_fin ? ST_SPATCH : ST_CLHDR;
                    n_cnt   = 5'd0;
                end
            end
            ST_CLHDR: begin
                if (w_adv) begin
                    if (r_cnt == w_hdr_last) begin
                        n_state = ST_BLOCK;
                        n_cnt   = 5'd0;
                    end else begin
                        n_cnt = r_cnt + 5'd1;
                    end
                end
            end
            ST_BLOCK: begin
                if (w_adv) begin
                    if (r_cnt == w_blk_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_cnt = r_cnt + 5'd1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_cnt          <= '0;
            r_out_valid    <= 1'b0;
            r_cl_open      <= 1'b0;
            r_cl_field_off <= '0;
            r_cl_start_ms  <= '0;
            r_out_off      <= '0;
            r_closed       <= 1'b0;
            r_seg_off      <= SEG_OFFSET_RESET;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (w_adv) begin
                r_out_valid <= w_emit;
            end
            if (i_cfg.we) begin
                case (i_cfg.index)
                    CFG_FIRST_CLUSTER: begin
                        if (!r_cl_open && !r_closed) begin
                            r_out_off <= OB'(i_cfg.data);
                        end
                    end
                    CFG_SEGMENT_DATA: begin
                        r_seg_off <= i_cfg.data;
                    end
                    default: begin
                    end
                endcase
            end
            if (w_emit) begin
                case (r_state)
                    ST_CPATCH: begin
                        r_cl_open <= 1'b0;
                    end
                    ST_SPATCH: begin
                        r_closed <= 1'b1;
                    end
                    ST_CLHDR: begin
                        r_out_off <= r_out_off + OB'(1);
                        if (r_cnt == 5'd4) begin
                            r_cl_field_off <= r_out_off;
                        end
                        if (r_cnt == w_hdr_last) begin
                            r_cl_open     <= 1'b1;
                            r_cl_start_ms <= r_ms;
                        end
                    end
                    ST_BLOCK: begin
                        if (r_cnt == w_blk_last) begin
                            r_out_off <= r_out_off + OB'(1) + OB'(r_plen);
                        end else begin
                            r_out_off <= r_out_off + OB'(1);
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // item latch and result register
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_fin   <= i_q_item.command;
            r_key   <= i_q_item.keyframe;
            r_ms    <= i_q_item.ms;
            r_plen  <= w_plen;
            r_rel   <= w_new ? 16'd0 : w_diff[15:0];
            r_n     <= w_n;
            r_szk   <= w_szk;
            r_szval <= w_szval;
        end
        if (w_emit) begin
            r_out <= w_res;
        end
    end

endmodule

>>> sv/webm_cluster_block_framer.sv
// ----------------------------------------------------------------------------
// webm_cluster_block_framer
// cluster and simpleblock header framer for a webm video track
// ----------------------------------------------------------------------------
// flow: a taken descriptor goes through the ns to ms divider, is pushed into
//   the queue and is dispatched by the byte sequencer, which then emits one
//   result per cycle while the result channel does not stall; a frame that
//   closes and opens a cluster gives the most results
// front divider takes a new descriptor only once the last division is done
// reset: synchronous, active low; no cluster open, output offset 0,
//   segment data offset 8, queue and result register empty
// ----------------------------------------------------------------------------
module webm_cluster_block_framer #(
    parameter int OFFSET_BITS       = 48,
    parameter int FRAME_LENGTH_BITS = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // descriptor channel
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  wcbf_pkg::t_wcbf_in                   i_in_data,
    // result channel
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output wcbf_pkg::t_wcbf_out                  o_out_data,
    // configuration writes
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [wcbf_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  logic [47:0]                          i_cfg_data
);
    import wcbf_pkg::*;

    logic       w_q_push;
    logic       w_q_full;
    logic       w_q_valid;
    logic       w_q_pop;
    t_wcbf_item w_push_item;
    t_wcbf_item w_head_item;
    t_wcbf_cfg  w_cfg;

    // registers are written in a single beat, never back-pressured
    assign o_cfg_ready  = 1'b1;
    assign w_cfg.we     = i_cfg_valid;
    assign w_cfg.index  = i_cfg_index;
    assign w_cfg.data   = i_cfg_data;

    // front: takes descriptors, converts the timestamp to milliseconds
    wcbf_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .i_q_full   (w_q_full),
        .o_q_push   (w_q_push),
        .o_q_item   (w_push_item)
    );

    // short queue so the divider and the byte sequencer stall independently
    wcbf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_item  (w_push_item),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .i_pop   (w_q_pop),
        .o_item  (w_head_item)
    );

    // back: cluster decisions, header bytes, size patches, result register
    wcbf_back #(
        .OFFSET_BITS       (OFFSET_BITS),
        .FRAME_LENGTH_BITS (FRAME_LENGTH_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_q_valid   (w_q_valid),
        .i_q_item    (w_head_item),
        .o_q_pop     (w_q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

>>> sim/webm_cluster_block_framer_tb.sv
// ----------------------------------------------------------------------------
// webm_cluster_block_framer_tb
// self-checking bench for the webm cluster and simpleblock framer
// ----------------------------------------------------------------------------
// frame descriptors go in through a valid/stall sender with random gaps, and
// every header byte, size patch and reject beat that comes out is checked
// against a cycle-free model of the framer kept inside the bench. the run
// covers ebml size boundaries, cluster changes by keyframe and by elapsed
// time, time going backward, offset wrap, register writes between phases,
// a finalize with an open cluster and input after the stream is closed
// ----------------------------------------------------------------------------
module webm_cluster_block_framer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import wcbf_pkg::*;

    // descriptor commands
    localparam logic CMD_FRAME    = 1'b0;
    localparam logic CMD_FINALIZE = 1'b1;

    // leading bytes of the longer ebml size codes
    localparam logic [7:0] VINT_LEN2 = 8'h40;
    localparam logic [7:0] VINT_LEN3 = 8'h20;
    localparam logic [7:0] VINT_LEN4 = 8'h10;
    localparam logic [7:0] VINT_LEN8 = 8'h01;
    localparam logic [7:0] NO_FLAGS  = 8'h00;

    localparam logic [47:0] OFFSET_MAX  = '1;
    localparam logic [62:0] TS_MAX      = '1;
    // highest ms value for which any sub-ms part still fits 63 bits
    localparam longint unsigned MS_CEIL = 64'd9223372036853;
    localparam int unsigned CYCLE_LIMIT = 1000000;
    localparam int unsigned RANDOM_PHASES    = 4;
    localparam int unsigned ITEMS_PER_PHASE  = 93;

    logic      i_clk;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_stall;
    t_wcbf_in  i_in_data   = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_wcbf_out o_out_data;
    logic      i_cfg_valid = 1'b0;
    logic      o_cfg_ready;
    logic [CFG_IDX_BITS-1:0] i_cfg_index = '0;
    logic [47:0]             i_cfg_data  = '0;

    webm_cluster_block_framer i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // framer model: register copies and stream state
    // ------------------------------------------------------------------------
    logic [47:0] reg_first_cluster = '0;
    logic [47:0] reg_segment_data  = SEG_OFFSET_RESET;
    logic        trk_open          = 1'b0;
    logic        trk_closed        = 1'b0;
    logic [47:0] trk_size_field    = '0;
    logic [63:0] trk_start_ms      = '0;
    logic [47:0] trk_offset        = '0;

    // beats still owed by the block, oldest first
    t_wcbf_out   pending_beats[$];

    int unsigned fail_count  = 0;
    int unsigned cycle_count = 0;
    int unsigned sink_wait   = 0;
    bit          quiet       = 1'b0;   // no gaps and no stalls while set
    longint unsigned now_ms  = 0;      // running presentation time of the random stream
    t_wcbf_out   want;

    function automatic void expect_beat(logic [1:0] kind, logic [7:0] b,
                                        logic [47:0] off, logic [55:0] len);
        t_wcbf_out r;
        r.kind         = kind;
        r.byte_value   = b;
        r.patch_offset = off;
        r.patch_length = len;
        r.last         = 1'b0;
        pending_beats.push_back(r);
    endfunction

    // every header byte moves the output position on by one
    function automatic void expect_header_byte(logic [7:0] b);
        expect_beat(KIND_BYTE, b, '0, '0);
        trk_offset = trk_offset + 48'd1;
    endfunction

    function automatic void expect_size_patch(logic [47:0] field, logic [47:0] len);
        expect_beat(KIND_PATCH, NO_FLAGS, field, {8'h00, len});
    endfunction

    // patch for the open cluster: bytes since the end of its size field
    function automatic void close_cluster_beats();
        expect_size_patch(trk_size_field, trk_offset - (trk_size_field + 48'd8));
        trk_open = 1'b0;
    endfunction

    // cluster id, unknown size and a minimal-length timecode element
    function automatic void open_cluster_beats(logic [63:0] ms);
        int n;
        trk_start_ms = ms;
        for (int i = 3; i >= 0; i--) expect_header_byte(CLUSTER_ID[8*i +: 8]);
        trk_size_field = trk_offset;
        expect_header_byte(UNKNOWN_LEAD);
        repeat (7) expect_header_byte(UNKNOWN_FILL);
        n = 1;
        while (n < 8 && (ms >> (8 * n)) != 64'd0) n++;
        expect_header_byte(TIMECODE_ID);
        expect_header_byte(VINT_LEN1 | 8'(n));
        for (int i = n - 1; i >= 0; i--) expect_header_byte(ms[8*i +: 8]);
        trk_open = 1'b1;
    endfunction

    // ebml size code, all-ones codes avoided at each length
    function automatic void ebml_size_beats(logic [63:0] s);
        if (s < 64'h7F) begin
            expect_header_byte(s[7:0] | VINT_LEN1);
        end else if (s < 64'h3FFF) begin
            expect_header_byte(s[15:8] | VINT_LEN2);
            expect_header_byte(s[7:0]);
        end else if (s < 64'h1FFFFF) begin
            expect_header_byte(s[23:16] | VINT_LEN3);
            expect_header_byte(s[15:8]);
            expect_header_byte(s[7:0]);
        end else if (s < 64'h0FFFFFFF) begin
            expect_header_byte(s[31:24] | VINT_LEN4);
            expect_header_byte(s[23:16]);
            expect_header_byte(s[15:8]);
            expect_header_byte(s[7:0]);
        end else begin
            expect_header_byte(VINT_LEN8);
            for (int i = 6; i >= 0; i--) expect_header_byte(s[8*i +: 8]);
        end
    endfunction

    // all beats that one accepted descriptor must produce
    function automatic void frame_header_beats(t_wcbf_in it);
        logic [63:0] ms;
        logic [15:0] rel;
        logic [47:0] seg;
        if (trk_closed) begin
            expect_beat(KIND_REJECT, NO_FLAGS, '0, '0);
        end else if (it.command == CMD_FINALIZE) begin
            seg = reg_segment_data;
            if (trk_open) close_cluster_beats();
            expect_size_patch(seg - 48'd8, trk_offset - seg);
            trk_closed = 1'b1;
        end else begin
            ms = {1'b0, it.timestamp_ns} / 64'(NS_PER_MS);
            // both times are below 2^44, so no signed compare is needed
            if (!trk_open || it.keyframe || ms > trk_start_ms + 64'(MAX_CLUSTER_MS)) begin
                if (trk_open) close_cluster_beats();
                open_cluster_beats(ms);
            end
            rel = ms[15:0] - trk_start_ms[15:0];
            expect_header_byte(SIMPLEBLOCK_ID);
            ebml_size_beats(64'(it.payload_length) + 64'd4);
            expect_header_byte(TRACK_BYTE);
            expect_header_byte(rel[15:8]);
            expect_header_byte(rel[7:0]);
            expect_header_byte(it.keyframe ? KEY_FLAG : NO_FLAGS);
            // payload bytes go elsewhere but still count
            trk_offset = trk_offset + {16'h0000, it.payload_length};
        end
        pending_beats[pending_beats.size() - 1].last = 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // result side: random stall per beat, compare against the oldest entry
    // ------------------------------------------------------------------------
    function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] got_v);
        if (got_v !== exp_v) begin
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, exp_v, got_v);
            fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall) begin
            if (pending_beats.size() == 0) begin
                $display("%0t: unexpected beat, expected none, got %p", $time, o_out_data);
                fail_count++;
            end else begin
                want = pending_beats.pop_front();
                check_field("kind", 64'(want.kind), 64'(o_out_data.kind));
                check_field("byte_value", 64'(want.byte_value), 64'(o_out_data.byte_value));
                check_field("patch_offset", 64'(want.patch_offset), 64'(o_out_data.patch_offset));
                check_field("patch_length", 64'(want.patch_length), 64'(o_out_data.patch_length));
                check_field("last", 64'(want.last), 64'(o_out_data.last));
            end
            sink_wait = quiet ? 0 : $urandom_range(0, 8);
        end
        // hold stall for the drawn number of cycles, then release
        if (sink_wait != 0) begin
            i_out_stall <= 1'b1;
            sink_wait--;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    // one descriptor beat; valid stays up on return so back-to-back beats
    // keep it high between them
    task automatic send_item(input t_wcbf_in it);
        int unsigned gap;
        gap = quiet ? 0 : $urandom_range(0, 8);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        frame_header_beats(it);
    endtask

    // stop sending and wait for every owed beat
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_beats.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [47:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        if (idx == CFG_FIRST_CLUSTER) begin
            reg_first_cluster = val;
            // only moves the output position before the first cluster opens
            if (!trk_open && !trk_closed) trk_offset = val;
        end else if (idx == CFG_SEGMENT_DATA) begin
            reg_segment_data = val;
        end
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [62:0] ms_ns(longint unsigned ms, int unsigned sub);
        return 63'(ms * 64'(NS_PER_MS) + 64'(sub));
    endfunction

    function automatic t_wcbf_in frame_item(logic [62:0] ts, logic key, logic [31:0] len);
        t_wcbf_in it;
        it.command        = CMD_FRAME;
        it.timestamp_ns   = ts;
        it.keyframe       = key;
        it.payload_length = len;
        return it;
    endfunction

    function automatic t_wcbf_in random_item();
        t_wcbf_in it;
        it.command        = $urandom_range(0, 1);
        it.timestamp_ns   = {31'($urandom), 32'($urandom)};
        it.keyframe       = $urandom_range(0, 1);
        it.payload_length = $urandom;
        return it;
    endfunction

    // payload length that lands on either side of an ebml size step
    function automatic logic [31:0] size_step_length();
        int unsigned k;
        k = $urandom_range(1, 4);
        return (32'd1 << (7 * k)) - 32'd5 - 32'($urandom_range(0, 1));
    endfunction

    // mostly steadily advancing video, with keyframes, cluster timeouts,
    // time going backward and the odd wild timestamp
    function automatic t_wcbf_in random_frame();
        t_wcbf_in        it;
        int unsigned     pick;
        longint unsigned back;
        it = random_item();
        it.command  = CMD_FRAME;
        it.keyframe = ($urandom_range(0, 9) == 0);
        pick = $urandom_range(0, 99);
        if (pick < 94) begin
            if (pick < 65) begin
                now_ms += $urandom_range(0, 400);
            end else if (pick < 77) begin
                now_ms += $urandom_range(4995, 5005);
            end else if (pick < 87) begin
                back   = $urandom_range(0, 70000);
                now_ms = (back > now_ms) ? 0 : now_ms - back;
            end else begin
                now_ms += $urandom;
            end
            if (now_ms > MS_CEIL) now_ms = MS_CEIL;
            it.timestamp_ns = ms_ns(now_ms, $urandom_range(0, 999999));
        end else begin
            now_ms = {1'b0, it.timestamp_ns} / 64'(NS_PER_MS);
        end
        case ($urandom_range(0, 5))
            0: it.payload_length = $urandom_range(0, 255);
            1: it.payload_length = $urandom_range(0, 32'h4000);
            2: it.payload_length = $urandom_range(32'h3FF0, 32'h20_0010);
            3: it.payload_length = $urandom_range(32'h1F_FFF0, 32'h1000_0010);
            4: it.payload_length = size_step_length();
            default: it.payload_length = $urandom;
        endcase
        return it;
    endfunction

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // both registers at their extremes; the first-cluster offset ends just
    // below the wrap point so the output position wraps inside the first cluster
    task automatic test_register_setup();
        write_reg(CFG_FIRST_CLUSTER, '0);
        write_reg(CFG_FIRST_CLUSTER, OFFSET_MAX);
        write_reg(CFG_SEGMENT_DATA, OFFSET_MAX);
        write_reg(CFG_SEGMENT_DATA, SEG_OFFSET_RESET);
        write_reg(CFG_FIRST_CLUSTER, OFFSET_MAX - 48'd39);
    endtask

    task automatic test_directed_frames();
        quiet = 1'b0;
        // no cluster open yet, time zero, empty payload
        send_item(frame_item('0, 1'b0, 32'd0));
        // size code steps: 1/2, 2/3, 3/4 and 4/8 bytes
        send_item(frame_item(ms_ns(100, 999999), 1'b0, 32'h7A));
        send_item(frame_item(ms_ns(200, 0), 1'b0, 32'h7B));
        send_item(frame_item(ms_ns(300, 0), 1'b0, 32'h3FFA));
        send_item(frame_item(ms_ns(400, 0), 1'b0, 32'h3FFB));
        send_item(frame_item(ms_ns(500, 0), 1'b0, 32'h1F_FFFA));
        send_item(frame_item(ms_ns(600, 0), 1'b0, 32'h1F_FFFB));
        send_item(frame_item(ms_ns(700, 0), 1'b0, 32'h0FFF_FFFA));
        // exactly at the cluster time limit: stays in the cluster
        send_item(frame_item(ms_ns(5000, 999999), 1'b0, 32'h0FFF_FFFB));
        // one ms past it: new cluster, largest payload
        send_item(frame_item(ms_ns(5001, 0), 1'b0, '1));
        // keyframe forces a new cluster
        send_item(frame_item(ms_ns(5101, 0), 1'b1, 32'd10));
        // time going backward, relative timecode wraps
        send_item(frame_item(ms_ns(4000, 0), 1'b0, 32'd5));
        // largest timestamp: six-byte cluster timecode
        send_item(frame_item(TS_MAX, 1'b0, 32'd0));
        // far backward: no new cluster, timecode modulo 2^16
        send_item(frame_item('0, 1'b0, 32'd1));
        send_item(frame_item(ms_ns(64'd9223372036854 - 70000, 0), 1'b0, 32'd3));
        send_item(frame_item(TS_MAX, 1'b1, '1));
        send_item(frame_item(ms_ns(64'd9223372036854, 0), 1'b0, 32'h7B));
        now_ms = MS_CEIL;
        // every owed beat back before the random part
        wait_drained();
    endtask

    task automatic test_random_frames();
        for (int unsigned p = 0; p < RANDOM_PHASES; p++) begin
            for (int unsigned k = 0; k < ITEMS_PER_PHASE; k++) begin
                // now and then a stretch with no gaps and no stalls
                if (k % 30 == 0) quiet = ($urandom_range(0, 3) == 0);
                if ($urandom_range(0, 15) == 0) now_ms = $urandom_range(0, 100000);
                send_item(random_frame());
            end
            quiet = 1'b0;
            wait_drained();
            // first-cluster offset no longer moves anything once a cluster is open
            write_reg(CFG_SEGMENT_DATA, (p == 0) ? OFFSET_MAX : {16'($urandom), 32'($urandom)});
            write_reg(CFG_FIRST_CLUSTER, {16'($urandom), 32'($urandom)});
        end
    endtask

    // segment offset below eight wraps the size field offset; the cluster
    // left open by the random part gets its own patch first
    task automatic test_finalize();
        t_wcbf_in it;
        it = random_item();
        it.command = CMD_FINALIZE;
        write_reg(CFG_SEGMENT_DATA, 48'd3);
        send_item(it);
        wait_drained();
    endtask

    // closed stream: every descriptor is rejected
    task automatic test_after_close();
        repeat (6) send_item(random_item());
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_register_setup();
        test_directed_frames();
        test_random_frames();
        test_finalize();
        test_after_close();
        wait_drained();
        // room for any stray beat to show up
        repeat (50) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
